@@ hdl/ats_pkg.sv @@
package ats_pkg;

  // number format and series limits
  localparam int MAX_TERMS  = 32;
  localparam int FRAC_BITS  = 29;
  localparam int RECIP_BITS = 32;

  localparam int X_W     = 32;                      // input argument width
  localparam int SUM_W   = 64;                      // power, term and sum width
  localparam int HALF_W  = 32;                      // multiplier a-operand slice
  localparam int X2_W    = 2 * X_W - FRAC_BITS - 1; // x squared never exceeds 2^(62-frac)
  localparam int MUL_B_W = (X2_W > RECIP_BITS) ? X2_W : RECIP_BITS;
  localparam int PP_W    = HALF_W + MUL_B_W;
  localparam int ACC_W   = SUM_W + MUL_B_W;
  localparam int K_W     = $clog2(MAX_TERMS);
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);
  localparam int TC_W    = 6;                       // term_count register width

  localparam logic [63:0] RECIP_ONE = 64'h1_0000_0000;

  // round(2^32 / (2k+1)), half up; the first term bypasses the table
  localparam logic [RECIP_BITS-1:0] RECIP_TAB [MAX_TERMS] = '{
    '0,
    32'((RECIP_ONE + 64'd1)  / 64'd3),  32'((RECIP_ONE + 64'd2)  / 64'd5),
    32'((RECIP_ONE + 64'd3)  / 64'd7),  32'((RECIP_ONE + 64'd4)  / 64'd9),
    32'((RECIP_ONE + 64'd5)  / 64'd11), 32'((RECIP_ONE + 64'd6)  / 64'd13),
    32'((RECIP_ONE + 64'd7)  / 64'd15), 32'((RECIP_ONE + 64'd8)  / 64'd17),
    32'((RECIP_ONE + 64'd9)  / 64'd19), 32'((RECIP_ONE + 64'd10) / 64'd21),
    32'((RECIP_ONE + 64'd11) / 64'd23), 32'((RECIP_ONE + 64'd12) / 64'd25),
    32'((RECIP_ONE + 64'd13) / 64'd27), 32'((RECIP_ONE + 64'd14) / 64'd29),
    32'((RECIP_ONE + 64'd15) / 64'd31), 32'((RECIP_ONE + 64'd16) / 64'd33),
    32'((RECIP_ONE + 64'd17) / 64'd35), 32'((RECIP_ONE + 64'd18) / 64'd37),
    32'((RECIP_ONE + 64'd19) / 64'd39), 32'((RECIP_ONE + 64'd20) / 64'd41),
    32'((RECIP_ONE + 64'd21) / 64'd43), 32'((RECIP_ONE + 64'd22) / 64'd45),
    32'((RECIP_ONE + 64'd23) / 64'd47), 32'((RECIP_ONE + 64'd24) / 64'd49),
    32'((RECIP_ONE + 64'd25) / 64'd51), 32'((RECIP_ONE + 64'd26) / 64'd53),
    32'((RECIP_ONE + 64'd27) / 64'd55), 32'((RECIP_ONE + 64'd28) / 64'd57),
    32'((RECIP_ONE + 64'd29) / 64'd59), 32'((RECIP_ONE + 64'd30) / 64'd61),
    32'((RECIP_ONE + 64'd31) / 64'd63)
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_LO,
    ST_SQ_WB,
    ST_TERM0,
    ST_SUM,
    ST_POW_LO,
    ST_POW_HI,
    ST_POW_WB,
    ST_REC_LO,
    ST_REC_HI,
    ST_REC_WB,
    ST_FIN
  } step_e;

  typedef enum logic {A_LO, A_HI} a_half_e;
  typedef enum logic [1:0] {B_SELF, B_X2, B_RECIP} mul_b_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_e;
  typedef enum logic [2:0] {WB_NONE, WB_X2, WB_POWER, WB_TERM, WB_COPY} wb_e;
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_NO_TERMS,
    COND_LAST_TERM,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    a_half_e a_half;
    mul_b_e  b_sel;
    acc_e    acc_op;
    wb_e     wb;
    logic    sum_en;
    logic    load_in;
    logic    out_load;
    cond_e   cond;
    step_e   jump;
    step_e   next;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic zero_terms;
    logic last_term;
    logic out_free;
  } status_t;

  function automatic ctrl_t cw(a_half_e ah, mul_b_e bs, acc_e ac, wb_e wb, logic se,
                               logic li, logic ol, cond_e c, step_e j, step_e n);
    ctrl_t w;
    w.a_half   = ah;
    w.b_sel    = bs;
    w.acc_op   = ac;
    w.wb       = wb;
    w.sum_en   = se;
    w.load_in  = li;
    w.out_load = ol;
    w.cond     = c;
    w.jump     = j;
    w.next     = n;
    return w;
  endfunction

  // microprogram: jump taken when the condition holds, else next
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    unique case (s)
      ST_IDLE:   w = cw(A_LO, B_SELF,  ACC_HOLD, WB_NONE,  1'b0, 1'b1, 1'b0,
                        COND_IN_VALID,  ST_SQ_LO,  ST_IDLE);
      ST_SQ_LO:  w = cw(A_LO, B_SELF,  ACC_LOAD, WB_NONE,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_SQ_WB,  ST_SQ_WB);
      ST_SQ_WB:  w = cw(A_LO, B_SELF,  ACC_HOLD, WB_X2,    1'b0, 1'b0, 1'b0,
                        COND_NO_TERMS,  ST_FIN,    ST_TERM0);
      ST_TERM0:  w = cw(A_LO, B_SELF,  ACC_HOLD, WB_COPY,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_SUM,    ST_SUM);
      ST_SUM:    w = cw(A_LO, B_SELF,  ACC_HOLD, WB_NONE,  1'b1, 1'b0, 1'b0,
                        COND_LAST_TERM, ST_FIN,    ST_POW_LO);
      ST_POW_LO: w = cw(A_LO, B_X2,    ACC_LOAD, WB_NONE,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_POW_HI, ST_POW_HI);
      ST_POW_HI: w = cw(A_HI, B_X2,    ACC_ADD,  WB_NONE,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_POW_WB, ST_POW_WB);
      ST_POW_WB: w = cw(A_LO, B_SELF,  ACC_HOLD, WB_POWER, 1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_REC_LO, ST_REC_LO);
      ST_REC_LO: w = cw(A_LO, B_RECIP, ACC_LOAD, WB_NONE,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_REC_HI, ST_REC_HI);
      ST_REC_HI: w = cw(A_HI, B_RECIP, ACC_ADD,  WB_NONE,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_REC_WB, ST_REC_WB);
      ST_REC_WB: w = cw(A_LO, B_SELF,  ACC_HOLD, WB_TERM,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_SUM,    ST_SUM);
      ST_FIN:    w = cw(A_LO, B_SELF,  ACC_HOLD, WB_NONE,  1'b0, 1'b0, 1'b1,
                        COND_OUT_FREE,  ST_IDLE,   ST_FIN);
      default:   w = cw(A_LO, B_SELF,  ACC_HOLD, WB_NONE,  1'b0, 1'b0, 1'b0,
                        COND_ALWAYS,    ST_IDLE,   ST_IDLE);
    endcase
    return w;
  endfunction

endpackage

@@ hdl/ats_if.sv @@
interface ats_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [ats_pkg::X_W-1:0]  x_value;

  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

interface ats_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ats_pkg::SUM_W-1:0] series_sum;
  logic                             overflow;

  modport source (output valid, output series_sum, output overflow, input ready);
  modport sink (input valid, input series_sum, input overflow, output ready);
endinterface

interface ats_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ats_pkg::TC_W-1:0]    term_count;

  modport source (output valid, output term_count, input ready);
  modport sink (input valid, input term_count, output ready);
endinterface

@@ hdl/ats_sequencer.sv @@
module ats_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ats_pkg::status_t status_i,
  output ats_pkg::ctrl_t   ctrl_o
);
  import ats_pkg::*;

  step_e step_q, step_d;
  logic  cond_met;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_comb begin
    ctrl_o = ucode(step_q);
    unique case (ctrl_o.cond)
      COND_ALWAYS:    cond_met = 1'b1;
      COND_IN_VALID:  cond_met = status_i.in_valid;
      COND_NO_TERMS:  cond_met = status_i.zero_terms;
      COND_LAST_TERM: cond_met = status_i.last_term;
      COND_OUT_FREE:  cond_met = status_i.out_free;
      default:        cond_met = 1'b1;
    endcase
    step_d = cond_met ? ctrl_o.jump : ctrl_o.next;
  end

endmodule

@@ hdl/ats_datapath.sv @@
module ats_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ats_pkg::ctrl_t                  ctrl_i,
  input  logic                            in_accept_i,
  input  logic signed [ats_pkg::X_W-1:0]  x_value_i,
  input  logic [ats_pkg::TC_W-1:0]        term_count_i,
  output logic                            zero_terms_o,
  output logic                            last_term_o,
  output logic [ats_pkg::SUM_W-1:0]       series_sum_o,
  output logic                            overflow_o
);
  import ats_pkg::*;

  localparam int RW = ACC_W + 1;

  logic             xneg_q, xneg_d;
  logic [SUM_W-1:0] pmag_q, pmag_d;
  logic [X2_W-1:0]  x2_q, x2_d;
  logic [SUM_W-1:0] tmag_q, tmag_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d;
  logic [K_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic [X_W-1:0]     xmag;
  logic [HALF_W-1:0]  mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PP_W-1:0]    pp;
  logic               use_rec;
  logic [RW-1:0]      rnd;
  logic [RW-1:0]      res_wide;
  logic [SUM_W-1:0]   plim;
  logic               too_big;
  logic [SUM_W-1:0]   res_sat;
  logic               tneg;
  logic [SUM_W-1:0]   tbits;
  logic [SUM_W-1:0]   add_s;
  logic               add_ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      n_q   <= '0;
      ovf_q <= 1'b0;
    end else begin
      k_q   <= k_d;
      n_q   <= n_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xneg_q <= xneg_d;
    pmag_q <= pmag_d;
    x2_q   <= x2_d;
    tmag_q <= tmag_d;
    sum_q  <= sum_d;
    acc_q  <= acc_d;
  end

  // shared 32 x b multiplier, a taken one half at a time
  always_comb begin
    mul_a = (ctrl_i.a_half == A_HI) ? pmag_q[SUM_W-1:HALF_W] : pmag_q[HALF_W-1:0];
    unique case (ctrl_i.b_sel)
      B_SELF:  mul_b = MUL_B_W'(pmag_q[HALF_W-1:0]);
      B_X2:    mul_b = MUL_B_W'(x2_q);
      B_RECIP: mul_b = MUL_B_W'(RECIP_TAB[k_q]);
      default: mul_b = '0;
    endcase
    pp = PP_W'(mul_a) * PP_W'(mul_b);
  end

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = ACC_W'(pp);
      ACC_ADD:  acc_d = acc_q + {pp, {HALF_W{1'b0}}};
      default:  acc_d = acc_q;
    endcase
  end

  // round half up, shift, saturate to the power limit
  always_comb begin
    use_rec  = (ctrl_i.wb == WB_TERM);
    rnd      = {1'b0, acc_q} + (use_rec ? (RW'(1) << (RECIP_BITS - 1))
                                        : (RW'(1) << (FRAC_BITS - 1)));
    res_wide = use_rec ? (rnd >> RECIP_BITS) : (rnd >> FRAC_BITS);
    plim     = {xneg_q, {(SUM_W - 1){~xneg_q}}};
    too_big  = (|res_wide[RW-1:SUM_W]) || (res_wide[SUM_W-1:0] > plim);
    res_sat  = too_big ? plim : res_wide[SUM_W-1:0];
  end

  // signed term into the saturating sum
  always_comb begin
    tneg    = xneg_q ^ k_q[0];
    tbits   = tneg ? (SUM_W'(0) - tmag_q) : tmag_q;
    add_s   = sum_q + tbits;
    add_ovf = (sum_q[SUM_W-1] == tbits[SUM_W-1]) && (add_s[SUM_W-1] != sum_q[SUM_W-1]);
  end

  always_comb begin
    xmag   = x_value_i[X_W-1] ? (X_W'(0) - X_W'(x_value_i)) : X_W'(x_value_i);
    xneg_d = xneg_q;
    pmag_d = pmag_q;
    x2_d   = x2_q;
    tmag_d = tmag_q;
    sum_d  = sum_q;
    ovf_d  = ovf_q;
    k_d    = k_q;
    n_d    = n_q;

    if (in_accept_i) begin
      xneg_d = x_value_i[X_W-1];
      pmag_d = SUM_W'(xmag);
      sum_d  = '0;
      ovf_d  = 1'b0;
      k_d    = '0;
      n_d    = (term_count_i > TC_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : CNT_W'(term_count_i);
    end

    unique case (ctrl_i.wb)
      WB_X2: begin
        x2_d  = res_sat[X2_W-1:0];
        ovf_d = ovf_d | too_big;
      end
      WB_POWER: begin
        pmag_d = res_sat;
        ovf_d  = ovf_d | too_big;
      end
      WB_TERM: begin
        tmag_d = res_sat;
        ovf_d  = ovf_d | too_big;
      end
      WB_COPY: begin
        tmag_d = pmag_q;
      end
      default: begin
      end
    endcase

    if (ctrl_i.sum_en) begin
      sum_d = add_ovf ? {sum_q[SUM_W-1], {(SUM_W - 1){~sum_q[SUM_W-1]}}} : add_s;
      ovf_d = ovf_d | add_ovf;
      k_d   = k_q + K_W'(1);
    end
  end

  assign zero_terms_o = (n_q == '0);
  assign last_term_o  = ((CNT_W'(k_q) + CNT_W'(1)) == n_q);
  assign series_sum_o = sum_q;
  assign overflow_o   = ovf_q;

endmodule

@@ hdl/arctan_taylor_series.sv @@
// arctangent taylor series: for each signed q2.29 word x the block returns the partial sum
// x - x^3/3 + x^5/5 - ... over term_count terms (register, reset 15, values above 32 count
// as 32, zero gives a zero sum) as a signed q34.29 word with an overflow flag that is set
// whenever the power or the sum saturated. a microprogram in a small rom steps one shared
// 32 x 34 multiplier: each odd power is the previous one times x squared and each term is
// the power times a reciprocal from a constant table, both taken as two half products and
// then rounded and saturated. from acceptance to the result register a word passes through
// the squaring of x and the copy of the first term, then seven microsteps per term, set by
// the two two-step multiplications, their write-backs and the sum update.
// one word is in work at a time; the next word is taken in the idle microstep right after
// the result has moved to the output register, even while that result still waits for the
// sink.
module arctan_taylor_series (
  input  logic      clk_i,
  input  logic      rst_ni,
  ats_in_if.sink    in_i,
  ats_out_if.source out_o,
  ats_cfg_if.sink   cfg_i
);
  import ats_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    in_accept;
  logic    out_free;
  logic    zero_terms;
  logic    last_term;

  logic [TC_W-1:0]  term_count_q, term_count_d;
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] series_sum_q, series_sum_d;
  logic             overflow_q, overflow_d;
  logic [SUM_W-1:0] dp_sum;
  logic             dp_ovf;

  // configuration: always ready; the user must write it only while idle, the block does not enforce it
  assign cfg_i.ready  = 1'b1;
  assign term_count_d = cfg_i.valid ? cfg_i.term_count : term_count_q;

  // input word taken only in the idle microstep
  assign in_i.ready = ctrl.load_in;
  assign in_accept  = in_i.valid & ctrl.load_in;

  // output register frees up in the cycle its word is taken
  assign out_free = ~out_valid_q | out_o.ready;

  assign status = '{
    in_valid:   in_i.valid,
    zero_terms: zero_terms,
    last_term:  last_term,
    out_free:   out_free
  };

  ats_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  ats_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_accept_i  (in_accept),
    .x_value_i    (in_i.x_value),
    .term_count_i (term_count_q),
    .zero_terms_o (zero_terms),
    .last_term_o  (last_term),
    .series_sum_o (dp_sum),
    .overflow_o   (dp_ovf)
  );

  // result register, loaded by the final microstep
  always_comb begin
    out_valid_d  = out_valid_q & ~out_o.ready;
    series_sum_d = series_sum_q;
    overflow_d   = overflow_q;
    if (ctrl.out_load && out_free) begin
      out_valid_d  = 1'b1;
      series_sum_d = dp_sum;
      overflow_d   = dp_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TC_W'(15);
      out_valid_q  <= 1'b0;
    end else begin
      term_count_q <= term_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    series_sum_q <= series_sum_d;
    overflow_q   <= overflow_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.series_sum = series_sum_q;
  assign out_o.overflow   = overflow_q;

endmodule

@@ sim/tb_arctan_taylor_series.sv @@
`timescale 1ns / 100ps

module tb_arctan_taylor_series;
  import ats_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int TERMS_AT_RESET = 15;
  localparam int WORDS_PER_SET  = 170;
  localparam int MAX_GAP        = 17;
  localparam int LONG_HOLD      = 600;     // well over two words at 32 terms
  localparam int FIRST_HOLD_AT  = 300;
  localparam int HOLD_SPACING   = 800;
  localparam int DRAIN_CYCLES   = 250;     // beyond the work on one word at 32 terms
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int REPORT_CAP     = 100;

  localparam logic [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

  // corner arguments; the first five also seed the random edge picks
  localparam logic [X_W-1:0] CORNER_X [18] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h2000_0000, 32'hE000_0000,          // +1.0 and -1.0
    32'h1000_0000, 32'hF000_0000,          // +0.5 and -0.5
    32'h4000_0000, 32'hC000_0000,          // +2.0 and -2.0
    32'h4666_6666, 32'hB999_999A,          // +-2.2: the power after the last of 15 terms would saturate
    32'h5555_5555, 32'hAAAA_AAAA,
    32'h1FFF_FFFF, 32'h3000_0000, 32'h0000_03E8
  };

  // term counts per set: the lone term, zero terms, full length, counts above
  // the maximum that must clip, and a few in between
  localparam logic [TC_W-1:0] SET_TERMS [10] = '{
    6'd1, 6'd0, 6'd32, 6'd63, 6'd2, 6'd33, 6'd7, 6'd31, 6'd15, 6'd3
  };

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } atan_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ats_in_if  in_if ();
  ats_out_if out_if ();
  ats_cfg_if cfg_if ();

  arctan_taylor_series uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // words waiting for the driver, and sums the block still owes us
  logic [X_W-1:0]  x_backlog [$];
  atan_res_t       sums_due [$];

  logic [SUM_W-1:0] inv_odd [MAX_TERMS];   // round(2^32 / (2k+1)), half up
  logic [TC_W-1:0]  terms_set = TC_W'(TERMS_AT_RESET);

  int unsigned words_queued = 0;           // words handed to the driver
  int unsigned sums_seen    = 0;           // result words taken from the block
  int unsigned fails        = 0;
  int unsigned hold_left    = 0;           // cycles of the long sink hold-off
  int unsigned next_hold_at = FIRST_HOLD_AT;
  int unsigned cycles       = 0;

  initial begin
    for (int k = 0; k < MAX_TERMS; k++) begin
      inv_odd[k] = ((64'd1 << RECIP_BITS) + 64'(k)) / 64'(2 * k + 1);
    end
  end

  // multiply, round half up, shift right and clip to lim; top bit flags a clip
  function automatic logic [SUM_W:0] scaled_round_sat(logic [SUM_W-1:0] a,
                                                      logic [SUM_W-1:0] b,
                                                      int unsigned sh,
                                                      logic [SUM_W-1:0] lim);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << (sh - 1));
    prod = prod >> sh;
    if (prod > {64'd0, lim}) begin
      return {1'b1, lim};
    end
    return {1'b0, prod[SUM_W-1:0]};
  endfunction

  // alternating odd-power series x - x^3/3 + x^5/5 - ... over the given count
  function automatic atan_res_t atan_partial_sum(logic [X_W-1:0] x,
                                                 logic [TC_W-1:0] terms);
    logic             neg;
    logic             hit;
    logic             ovf;
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] x_sq;
    logic [SUM_W-1:0] lim;
    logic [SUM_W-1:0] pw;
    logic [SUM_W-1:0] tm;
    logic [SUM_W-1:0] tsigned;
    logic [SUM_W-1:0] acc;
    logic [SUM_W-1:0] nxt;
    int               n;
    atan_res_t        res;
    neg  = x[X_W-1];
    mag  = neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
    x_sq = (mag * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = neg ? SUM_MIN : SUM_MAX;
    pw   = mag;
    acc  = '0;
    ovf  = 1'b0;
    n    = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
    for (int k = 0; k < n; k++) begin
      // the power is only stepped when another term follows
      if (k > 0) begin
        {hit, pw} = scaled_round_sat(pw, x_sq, FRAC_BITS, lim);
        ovf = ovf | hit;
      end
      {hit, tm} = scaled_round_sat(pw, inv_odd[k], RECIP_BITS, lim);
      ovf = ovf | hit;
      tsigned = (neg ^ k[0]) ? (64'd0 - tm) : tm;
      nxt = acc + tsigned;
      if ((acc[SUM_W-1] == tsigned[SUM_W-1]) && (nxt[SUM_W-1] != acc[SUM_W-1])) begin
        ovf = 1'b1;
        nxt = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
      end
      acc = nxt;
    end
    res.sum = acc;
    res.ovf = ovf;
    return res;
  endfunction

  // input driver: offers backlog words with a random gap after each accepted
  // word, or none at all while in a burst; the expected sum is worked out at
  // acceptance with the term count then in force
  always @(posedge clk_i) begin : x_feed
    int unsigned gap;
    int unsigned src_wait;
    bit          src_burst;
    if (in_if.valid && in_if.ready) begin
      sums_due.push_back(atan_partial_sum(in_if.x_value, terms_set));
      gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) begin
        src_burst = ~src_burst;
      end
      if ((gap == 0) && (x_backlog.size() != 0)) begin
        // valid stays high, next word follows straight away
        in_if.x_value <= x_backlog.pop_front();
      end else begin
        in_if.valid <= 1'b0;
        src_wait = gap;
      end
    end else if (!in_if.valid) begin
      if (src_wait != 0) begin
        src_wait--;
      end else if (x_backlog.size() != 0) begin
        in_if.x_value <= x_backlog.pop_front();
        in_if.valid   <= 1'b1;
      end
    end
  end

  // long hold-off of the sink, counted on its own, so that the block fills
  // up (one word in work, one in the output register) and stalls its input
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (sums_seen == next_hold_at) begin
      hold_left    <= LONG_HOLD;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end
  end

  // result monitor: every accepted word is checked against the oldest sum due
  always @(posedge clk_i) begin : sum_check
    atan_res_t   want;
    logic        rdy_next;
    int unsigned sink_wait;
    bit          sink_burst;
    rdy_next = out_if.ready;
    if (out_if.valid && out_if.ready) begin
      sums_seen <= sums_seen + 1;
      if (sums_due.size() == 0) begin
        fails++;
        if (fails <= REPORT_CAP) begin
          $display("%0t: unexpected result word, expected none, got sum %h overflow %b",
                   $time, out_if.series_sum, out_if.overflow);
        end
      end else begin
        want = sums_due.pop_front();
        if (out_if.series_sum !== want.sum) begin
          fails++;
          if (fails <= REPORT_CAP) begin
            $display("%0t: series_sum expected %h, got %h",
                     $time, want.sum, out_if.series_sum);
          end
        end
        if (out_if.overflow !== want.ovf) begin
          fails++;
          if (fails <= REPORT_CAP) begin
            $display("%0t: overflow expected %b, got %b",
                     $time, want.ovf, out_if.overflow);
          end
        end
      end
      sink_wait = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 49) == 0) begin
        sink_burst = ~sink_burst;
      end
      rdy_next = (sink_wait == 0);
    end else if (!out_if.ready) begin
      if (sink_wait != 0) begin
        sink_wait--;
      end
      rdy_next = (sink_wait == 0);
    end
    if (hold_left != 0) begin
      rdy_next = 1'b0;
    end
    out_if.ready <= rdy_next;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // term count register write; only issued while the block is idle
  task automatic write_terms(input logic [TC_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.term_count <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    terms_set = value;
  endtask

  // sender pause: nothing more goes in until every result is back
  task automatic wait_all_back();
    while (sums_seen < words_queued) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [X_W-1:0] x;
    logic [X_W-1:0] m;
    in_if.valid       = 1'b0;
    in_if.x_value     = '0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.term_count = '0;
    rst_ni            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners under the reset term count
    foreach (CORNER_X[i]) begin
      x_backlog.push_back(CORNER_X[i]);
      words_queued++;
    end

    foreach (SET_TERMS[s]) begin
      wait_all_back();
      write_terms(SET_TERMS[s]);
      for (int i = 0; i < WORDS_PER_SET; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: x = $urandom;
          // inside the unit interval, where the series converges
          4, 5, 6: x = 32'($urandom_range(0, 1 << 30)) - 32'(1 << 29);
          // around plus or minus one
          7: x = ($urandom_range(0, 1) ? 32'h2000_0000 : 32'hE000_0000)
                 + 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
          // large magnitudes, where power and sum saturate
          8: begin
            m = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
            x = $urandom_range(0, 1) ? m : (32'd0 - m);
          end
          default: x = CORNER_X[$urandom_range(0, 4)];
        endcase
        x_backlog.push_back(x);
        words_queued++;
      end
    end

    wait_all_back();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ats_pkg.sv
hdl/ats_if.sv
hdl/ats_sequencer.sv
hdl/ats_datapath.sv
hdl/arctan_taylor_series.sv
sim/tb_arctan_taylor_series.sv
